// ----- sv/vhp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the VBR info header parser.
// No dependencies; every other file in this folder refers to it by scoped names.
package vhp_pkg;

	// Default seek-table length
	localparam int TOC_ENTRIES_DEF = 100;

	// Result kinds
	localparam logic [1:0] KIND_TOC     = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_NONE    = 2'd2;

	// Info block offsets, counted from the sync byte
	localparam logic [7:0] OFF_M1_STEREO = 8'd36;
	localparam logic [7:0] OFF_M1_MONO   = 8'd21;
	localparam logic [7:0] OFF_M2_STEREO = 8'd21;
	localparam logic [7:0] OFF_M2_MONO   = 8'd13;
	localparam logic [1:0] MODE_MONO     = 2'd3;

	// Sample rates by rate index (MPEG-1)
	localparam logic [16:0] RATE_0 = 17'd44100;
	localparam logic [16:0] RATE_1 = 17'd48000;
	localparam logic [16:0] RATE_2 = 17'd32000;
	localparam logic [16:0] RATE_3 = 17'd99999;

	// Magic word "Xing"
	localparam logic [7:0] MAGIC_0 = 8'h58;
	localparam logic [7:0] MAGIC_1 = 8'h69;
	localparam logic [7:0] MAGIC_2 = 8'h6E;
	localparam logic [7:0] MAGIC_3 = 8'h67;

	localparam logic [31:0] SCALE_ABSENT = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR,
		PH_FLAGS,
		PH_FRAMES,
		PH_BYTES,
		PH_TOC,
		PH_SCALE,
		PH_PEND
	} phase_t;

	// One input item as held in the input register
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} item_t;

	// One result item
	typedef struct packed {
		logic [1:0]         kind;
		logic [6:0]         toc_index;
		logic [7:0]         toc_value;
		logic [31:0]        flag_word;
		logic [31:0]        frame_count;
		logic [31:0]        byte_count;
		logic signed [31:0] quality_scale;
		logic               is_mpeg1;
		logic [16:0]        sample_rate;
	} result_t;

	// Handshake between pipeline stages
	typedef struct packed {
		logic vld;  // item held in the input register
		logic adv;  // result register can take the step this cycle
	} stage_ctl_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] k);
		logic [7:0] m;
		unique case (k)
			2'd0: m = MAGIC_0;
			2'd1: m = MAGIC_1;
			2'd2: m = MAGIC_2;
			default: m = MAGIC_3;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] block_offset(input logic ver, input logic [1:0] mode);
		logic [7:0] o;
		if (ver)
			o = (mode != MODE_MONO) ? OFF_M1_STEREO : OFF_M1_MONO;
		else
			o = (mode != MODE_MONO) ? OFF_M2_STEREO : OFF_M2_MONO;
		return o;
	endfunction

	function automatic logic [16:0] sample_rate_of(input logic ver, input logic [1:0] idx);
		logic [16:0] r;
		unique case (idx)
			2'd0: r = RATE_0;
			2'd1: r = RATE_1;
			2'd2: r = RATE_2;
			default: r = RATE_3;
		endcase
		if (!ver)
			r = r >> 1;
		return r;
	endfunction

	// Next optional field after phase ph, given the low flag bits; PH_IDLE means none left
	function automatic phase_t next_after(input phase_t ph, input logic [3:0] f);
		phase_t n;
		if (ph == PH_FLAGS && f[0])
			n = PH_FRAMES;
		else if ((ph == PH_FLAGS || ph == PH_FRAMES) && f[1])
			n = PH_BYTES;
		else if ((ph == PH_FLAGS || ph == PH_FRAMES || ph == PH_BYTES) && f[2])
			n = PH_TOC;
		else if ((ph == PH_FLAGS || ph == PH_FRAMES || ph == PH_BYTES || ph == PH_TOC)
				&& f[3])
			n = PH_SCALE;
		else
			n = PH_IDLE;
		return n;
	endfunction

	function automatic result_t make_summary(
		input logic [31:0] flags,
		input logic [31:0] frames,
		input logic [31:0] bytes,
		input logic [31:0] scale,
		input logic        ver,
		input logic [1:0]  idx
	);
		result_t r;
		r               = '0;
		r.kind          = KIND_SUMMARY;
		r.flag_word     = flags;
		r.frame_count   = frames;
		r.byte_count    = bytes;
		r.quality_scale = scale;
		r.is_mpeg1      = ver;
		r.sample_rate   = sample_rate_of(ver, idx);
		return r;
	endfunction

endpackage

// ----- sv/vhp_in_reg.sv -----
`timescale 1ns / 1ps
// Input register stage: takes one byte transfer per cycle while the held byte can move on, and holds it for the parser.
// Depends on vhp_pkg (item_t).
module vhp_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               data_valid,
	output logic               data_ready,
	input  logic [7:0]         data_byte,
	input  logic               frame_start,
	input  logic               adv,
	output vhp_pkg::item_t     item_s1,
	output logic               vld_s1
);

	// Free when empty or when the held byte moves on this cycle
	assign data_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (data_ready) begin
			vld_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && data_ready) begin
			item_s1.data_byte   <= data_byte;
			item_s1.frame_start <= frame_start;
		end
	end

endmodule

// ----- sv/vhp_parser.sv -----
`timescale 1ns / 1ps
// Parse state and per-byte step logic: header decode, magic check, field assembly.
// Depends on vhp_pkg (phase_t, item_t, result_t, stage_ctl_t, helper functions).
module vhp_parser #(
	parameter int TOC_ENTRIES = vhp_pkg::TOC_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vhp_pkg::stage_ctl_t ctl,
	input  vhp_pkg::item_t      item_s1,
	output logic                res_hit,
	output vhp_pkg::result_t    res
);

	localparam int CW = ($clog2(TOC_ENTRIES) > 2) ? $clog2(TOC_ENTRIES) : 2;
	localparam logic [CW-1:0] TOC_LAST  = CW'(TOC_ENTRIES - 1);
	localparam logic [CW-1:0] FIELD_END = CW'(3);

	vhp_pkg::phase_t phase_q, phase_d;
	logic [7:0]  pos_q, pos_d;
	logic        ver_q, ver_d;
	logic [1:0]  rate_q, rate_d;
	logic [1:0]  mode_q, mode_d;
	logic [31:0] shift_q, shift_d;
	logic [31:0] flags_q, flags_d;
	logic [31:0] frames_q, frames_d;
	logic [31:0] bytes_q, bytes_d;
	logic [CW-1:0] cur_q, cur_d;

	logic        en;
	logic [7:0]  b;
	logic [31:0] shift_nx;
	logic [7:0]  off;
	logic [7:0]  rel;
	logic        in_magic;
	logic [31:0] flags_eff, frames_eff, bytes_eff;
	vhp_pkg::phase_t nxt;

	assign en       = ctl.vld && ctl.adv;
	assign b        = item_s1.data_byte;
	assign shift_nx = {shift_q[23:0], b};
	assign off      = vhp_pkg::block_offset(ver_q, mode_q);
	assign rel      = pos_q - off;
	assign in_magic = (pos_q >= off) && (rel < 8'd4);

	// A field that completes this byte is already visible to the flag decode and summary
	assign flags_eff  = (phase_q == vhp_pkg::PH_FLAGS)  ? shift_nx : flags_q;
	assign frames_eff = (phase_q == vhp_pkg::PH_FRAMES) ? shift_nx : frames_q;
	assign bytes_eff  = (phase_q == vhp_pkg::PH_BYTES)  ? shift_nx : bytes_q;
	assign nxt        = vhp_pkg::next_after(phase_q, flags_eff[3:0]);

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		ver_d    = ver_q;
		rate_d   = rate_q;
		mode_d   = mode_q;
		shift_d  = shift_q;
		flags_d  = flags_q;
		frames_d = frames_q;
		bytes_d  = bytes_q;
		cur_d    = cur_q;
		res_hit  = 1'b0;
		res      = '0;

		if (item_s1.frame_start) begin
			// a summary still owed goes out on the new sync byte
			if (phase_q == vhp_pkg::PH_PEND) begin
				res_hit = 1'b1;
				res     = vhp_pkg::make_summary(flags_q, frames_q, bytes_q,
					vhp_pkg::SCALE_ABSENT, ver_q, rate_q);
			end
			phase_d  = vhp_pkg::PH_HDR;
			pos_d    = 8'd1;
			ver_d    = 1'b0;
			rate_d   = 2'd0;
			mode_d   = 2'd0;
			shift_d  = '0;
			flags_d  = '0;
			frames_d = '0;
			bytes_d  = '0;
			cur_d    = '0;
		end else begin
			case (phase_q)
				vhp_pkg::PH_IDLE: begin
				end
				vhp_pkg::PH_PEND: begin
					res_hit = 1'b1;
					res     = vhp_pkg::make_summary(flags_q, frames_q, bytes_q,
						vhp_pkg::SCALE_ABSENT, ver_q, rate_q);
					phase_d = vhp_pkg::PH_IDLE;
				end
				vhp_pkg::PH_HDR: begin
					if (pos_q == 8'd1)
						ver_d = b[3];
					else if (pos_q == 8'd2)
						rate_d = b[3:2];
					else if (pos_q == 8'd3)
						mode_d = b[7:6];
					if (in_magic && (b != vhp_pkg::magic_byte(rel[1:0]))) begin
						res_hit  = 1'b1;
						res.kind = vhp_pkg::KIND_NONE;
						phase_d  = vhp_pkg::PH_IDLE;
					end else begin
						if (in_magic && (rel[1:0] == 2'd3)) begin
							phase_d = vhp_pkg::PH_FLAGS;
							cur_d   = '0;
							shift_d = '0;
						end
						if (pos_q != 8'hFF)
							pos_d = pos_q + 8'd1;
					end
				end
				vhp_pkg::PH_TOC: begin
					res_hit       = 1'b1;
					res.kind      = vhp_pkg::KIND_TOC;
					res.toc_index = 7'(cur_q);
					res.toc_value = b;
					if (cur_q == TOC_LAST) begin
						cur_d   = '0;
						phase_d = flags_q[3] ? vhp_pkg::PH_SCALE : vhp_pkg::PH_PEND;
					end else begin
						cur_d = cur_q + CW'(1);
					end
				end
				default: begin
					// four-byte big-endian fields: flags, frame count, byte count, scale
					if (cur_q != FIELD_END) begin
						shift_d = shift_nx;
						cur_d   = cur_q + CW'(1);
					end else begin
						cur_d   = '0;
						shift_d = '0;
						if (phase_q == vhp_pkg::PH_FLAGS)
							flags_d = shift_nx;
						if (phase_q == vhp_pkg::PH_FRAMES)
							frames_d = shift_nx;
						if (phase_q == vhp_pkg::PH_BYTES)
							bytes_d = shift_nx;
						if (phase_q == vhp_pkg::PH_SCALE) begin
							res_hit = 1'b1;
							res     = vhp_pkg::make_summary(flags_q, frames_q, bytes_q,
								shift_nx, ver_q, rate_q);
							phase_d = vhp_pkg::PH_IDLE;
						end else if (nxt == vhp_pkg::PH_IDLE) begin
							res_hit = 1'b1;
							res     = vhp_pkg::make_summary(flags_eff, frames_eff, bytes_eff,
								vhp_pkg::SCALE_ABSENT, ver_q, rate_q);
							phase_d = vhp_pkg::PH_IDLE;
						end else begin
							phase_d = nxt;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= vhp_pkg::PH_IDLE;
			pos_q    <= '0;
			ver_q    <= 1'b0;
			rate_q   <= '0;
			mode_q   <= '0;
			shift_q  <= '0;
			flags_q  <= '0;
			frames_q <= '0;
			bytes_q  <= '0;
			cur_q    <= '0;
		end else if (en) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			ver_q    <= ver_d;
			rate_q   <= rate_d;
			mode_q   <= mode_d;
			shift_q  <= shift_d;
			flags_q  <= flags_d;
			frames_q <= frames_d;
			bytes_q  <= bytes_d;
			cur_q    <= cur_d;
		end
	end

endmodule

// ----- sv/vhp_out_reg.sv -----
`timescale 1ns / 1ps
// Result register: holds one result until the receiver takes the transfer.
// Depends on vhp_pkg (result_t).
module vhp_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             res_hit,
	input  vhp_pkg::result_t res,
	input  logic             result_ready,
	output logic             adv,
	output logic             result_valid,
	output vhp_pkg::result_t res_q
);

	// The register can be overwritten when empty or drained this cycle
	assign adv = !result_valid || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= step && res_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && step && res_hit) begin
			res_q <= res;
		end
	end

endmodule

// ----- sv/vbr_header_parser_core.sv -----
`timescale 1ns / 1ps
// VBR info header parser, top level: input register, parse step, result register.
// Depends on vhp_pkg, vhp_in_reg, vhp_parser and vhp_out_reg.
//
// Usage
//   Frame bytes enter on the data channel (data_valid / data_ready), one byte per
//   transfer, with frame_start high on the sync byte of each frame. Bytes before the
//   first frame start, and after a parse has finished, are dropped.
//   Results leave on the result channel (result_valid / result_ready): one transfer
//   per seek-table byte (kind 0), then one summary (kind 1), or a single failure
//   (kind 2) on the first byte that breaks the magic word.
// Timing
//   A byte in the input register is parsed, and any result it causes is loaded into
//   the result register once that register can take it. The parse step is one pass
//   of compare-and-shift logic between the input register and the result register,
//   so one byte is taken in every cycle while the receiver keeps up.
// Reset
//   arst_n clears both valid flags and leaves the parser idle until a frame start.
// Stall
//   While result_ready is low a shown result holds; the byte behind it waits in the
//   input register, and data_ready drops only once that register is also full.
module vbr_header_parser_core #(
	parameter int TOC_ENTRIES = vhp_pkg::TOC_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               data_valid,
	output logic               data_ready,
	input  logic [7:0]         data_byte,
	input  logic               frame_start,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [1:0]         kind,
	output logic [6:0]         toc_index,
	output logic [7:0]         toc_value,
	output logic [31:0]        flag_word,
	output logic [31:0]        frame_count,
	output logic [31:0]        byte_count,
	output logic signed [31:0] quality_scale,
	output logic               is_mpeg1,
	output logic [16:0]        sample_rate
);

	vhp_pkg::item_t      item_s1;
	vhp_pkg::stage_ctl_t ctl;
	vhp_pkg::result_t    res;
	vhp_pkg::result_t    res_q;
	logic                vld_s1;
	logic                adv;
	logic                res_hit;

	assign ctl.vld = vld_s1;
	assign ctl.adv = adv;

	// Hold the incoming byte transfer
	vhp_in_reg u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_valid  (data_valid),
		.data_ready  (data_ready),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.adv         (adv),
		.item_s1     (item_s1),
		.vld_s1      (vld_s1)
	);

	// Advance the parse by one byte whenever the result side can take it
	vhp_parser #(
		.TOC_ENTRIES (TOC_ENTRIES)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.item_s1 (item_s1),
		.res_hit (res_hit),
		.res     (res)
	);

	// Hold each result until its transfer completes
	vhp_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (vld_s1),
		.res_hit      (res_hit),
		.res          (res),
		.result_ready (result_ready),
		.adv          (adv),
		.result_valid (result_valid),
		.res_q        (res_q)
	);

	assign kind          = res_q.kind;
	assign toc_index     = res_q.toc_index;
	assign toc_value     = res_q.toc_value;
	assign flag_word     = res_q.flag_word;
	assign frame_count   = res_q.frame_count;
	assign byte_count    = res_q.byte_count;
	assign quality_scale = res_q.quality_scale;
	assign is_mpeg1      = res_q.is_mpeg1;
	assign sample_rate   = res_q.sample_rate;

endmodule

// ----- sv/vhp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the VBR info header parser, bound to the top level.
// Depends on vhp_pkg (result kinds and sample-rate constants).
module vhp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               data_ready,
	input logic               result_valid,
	input logic               result_ready,
	input logic [1:0]         kind,
	input logic [31:0]        flag_word,
	input logic [31:0]        frame_count,
	input logic [31:0]        byte_count,
	input logic signed [31:0] quality_scale,
	input logic               is_mpeg1,
	input logic [16:0]        sample_rate
);

	// A stalled result holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(kind) && $stable(flag_word))
		else $error("result dropped or changed while stalled");

	// Only the three defined kinds leave the block
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (kind == vhp_pkg::KIND_TOC || kind == vhp_pkg::KIND_SUMMARY
			|| kind == vhp_pkg::KIND_NONE))
		else $error("undefined result kind");

	// Summary fields read zero on table entries and failures
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != vhp_pkg::KIND_SUMMARY |-> flag_word == '0
			&& frame_count == '0 && byte_count == '0 && quality_scale == '0
			&& !is_mpeg1 && sample_rate == '0)
		else $error("summary fields set on a non-summary result");

	// Summary rate comes from the table, halved for MPEG-2
	a_rate: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == vhp_pkg::KIND_SUMMARY |->
			(is_mpeg1 && (sample_rate == vhp_pkg::RATE_0 || sample_rate == vhp_pkg::RATE_1
				|| sample_rate == vhp_pkg::RATE_2 || sample_rate == vhp_pkg::RATE_3))
			|| (!is_mpeg1 && (sample_rate == (vhp_pkg::RATE_0 >> 1)
				|| sample_rate == (vhp_pkg::RATE_1 >> 1)
				|| sample_rate == (vhp_pkg::RATE_2 >> 1)
				|| sample_rate == (vhp_pkg::RATE_3 >> 1))))
		else $error("summary sample rate not from the rate table");

	// Input side is free straight out of reset
	a_ready_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> data_ready)
		else $error("input not ready after reset");

endmodule

bind vbr_header_parser_core vhp_checker u_vhp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.data_ready    (data_ready),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.kind          (kind),
	.flag_word     (flag_word),
	.frame_count   (frame_count),
	.byte_count    (byte_count),
	.quality_scale (quality_scale),
	.is_mpeg1      (is_mpeg1),
	.sample_rate   (sample_rate)
);

// ----- bench/tb_vbr_header_parser_core.sv -----
`timescale 1ns / 1ps
// Self-checking bench for vbr_header_parser_core: frame bytes in, seek-table and summary results out.
// Depends on vhp_pkg and the core RTL; no files, no arguments.
module tb_vbr_header_parser_core;

	localparam int TOC_LEN     = vhp_pkg::TOC_ENTRIES_DEF;
	localparam int RAND_ITEMS  = 1530;
	localparam int CYCLE_LIMIT = 200000;

	// How a directed row is checked
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NO_RESULT,
		CHK_TYPED
	} row_check_t;

	typedef struct packed {
		logic [7:0] data;
		logic       sync;
	} frame_byte_t;

	typedef struct packed {
		logic [7:0]       data;
		logic             sync;
		row_check_t       how;
		vhp_pkg::result_t typed;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               data_valid;
	logic               data_ready;
	logic [7:0]         data_byte;
	logic               frame_start;
	logic               result_valid;
	logic               result_ready;
	logic [1:0]         kind;
	logic [6:0]         toc_index;
	logic [7:0]         toc_value;
	logic [31:0]        flag_word;
	logic [31:0]        frame_count;
	logic [31:0]        byte_count;
	logic signed [31:0] quality_scale;
	logic               is_mpeg1;
	logic [16:0]        sample_rate;

	// Parser state as the bench tracks it; PH_IDLE stands for "parse finished"
	vhp_pkg::phase_t ps_phase;
	logic [7:0]  ps_pos;
	logic        ps_ver;
	logic [1:0]  ps_rix;
	logic [1:0]  ps_mode;
	logic [31:0] ps_shift;
	logic [31:0] ps_flags;
	logic [31:0] ps_frames;
	logic [31:0] ps_bytes;
	logic [7:0]  ps_cursor;

	vhp_pkg::result_t awaited_results [$];
	frame_byte_t byte_plan [$];
	logic [7:0]  frame_bytes [$];
	stim_row_t   dir_rows [23];
	row_check_t  row_check;
	vhp_pkg::result_t row_typed;
	int          src_idle_pct;
	int          mismatch_count = 0;
	int          cycle_no = 0;

	vbr_header_parser_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_valid    (data_valid),
		.data_ready    (data_ready),
		.data_byte     (data_byte),
		.frame_start   (frame_start),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.kind          (kind),
		.toc_index     (toc_index),
		.toc_value     (toc_value),
		.flag_word     (flag_word),
		.frame_count   (frame_count),
		.byte_count    (byte_count),
		.quality_scale (quality_scale),
		.is_mpeg1      (is_mpeg1),
		.sample_rate   (sample_rate)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Start of the info block, counted from the sync byte
	function automatic int info_offset();
		if (ps_ver)
			return (ps_mode != vhp_pkg::MODE_MONO) ? vhp_pkg::OFF_M1_STEREO
				: vhp_pkg::OFF_M1_MONO;
		return (ps_mode != vhp_pkg::MODE_MONO) ? vhp_pkg::OFF_M2_STEREO
			: vhp_pkg::OFF_M2_MONO;
	endfunction

	// Optional field that follows ph, or PH_IDLE when the flags name no more
	function automatic vhp_pkg::phase_t following_field(input vhp_pkg::phase_t ph);
		if (ph < vhp_pkg::PH_FRAMES && ps_flags[0])
			return vhp_pkg::PH_FRAMES;
		if (ph < vhp_pkg::PH_BYTES && ps_flags[1])
			return vhp_pkg::PH_BYTES;
		if (ph < vhp_pkg::PH_TOC && ps_flags[2])
			return vhp_pkg::PH_TOC;
		if (ph < vhp_pkg::PH_SCALE && ps_flags[3])
			return vhp_pkg::PH_SCALE;
		return vhp_pkg::PH_IDLE;
	endfunction

	function automatic vhp_pkg::result_t xing_summary(input logic [31:0] scale);
		vhp_pkg::result_t s;
		logic [16:0]      hz;
		case (ps_rix)
			2'd0: hz = vhp_pkg::RATE_0;
			2'd1: hz = vhp_pkg::RATE_1;
			2'd2: hz = vhp_pkg::RATE_2;
			default: hz = vhp_pkg::RATE_3;
		endcase
		// MPEG-2 runs at half the MPEG-1 rate
		if (!ps_ver)
			hz = hz >> 1;
		s               = '0;
		s.kind          = vhp_pkg::KIND_SUMMARY;
		s.flag_word     = ps_flags;
		s.frame_count   = ps_frames;
		s.byte_count    = ps_bytes;
		s.quality_scale = scale;
		s.is_mpeg1      = ps_ver;
		s.sample_rate   = hz;
		return s;
	endfunction

	task automatic clear_parse_state();
		ps_pos    = 8'd0;
		ps_ver    = 1'b0;
		ps_rix    = 2'd0;
		ps_mode   = 2'd0;
		ps_shift  = '0;
		ps_flags  = '0;
		ps_frames = '0;
		ps_bytes  = '0;
		ps_cursor = 8'd0;
	endtask

	// Advance the tracked parser by one accepted byte; got is set when it yields a result
	task automatic parse_frame_byte(input logic [7:0] b, input logic sync,
			output bit got, output vhp_pkg::result_t r);
		int         off;
		int         k;
		logic [7:0] magic [4];
		magic = '{vhp_pkg::MAGIC_0, vhp_pkg::MAGIC_1, vhp_pkg::MAGIC_2, vhp_pkg::MAGIC_3};
		got   = 1'b0;
		r     = '0;
		if (sync) begin
			// a summary still waiting for its trailing byte goes out on the new sync byte
			if (ps_phase == vhp_pkg::PH_PEND) begin
				r   = xing_summary(vhp_pkg::SCALE_ABSENT);
				got = 1'b1;
			end
			clear_parse_state();
			ps_phase = vhp_pkg::PH_HDR;
			ps_pos   = 8'd1;
		end else if (ps_phase == vhp_pkg::PH_IDLE) begin
			got = 1'b0;
		end else if (ps_phase == vhp_pkg::PH_PEND) begin
			r        = xing_summary(vhp_pkg::SCALE_ABSENT);
			got      = 1'b1;
			ps_phase = vhp_pkg::PH_IDLE;
		end else if (ps_phase == vhp_pkg::PH_HDR) begin
			off = info_offset();
			case (ps_pos)
				8'd1: ps_ver = b[3];
				8'd2: ps_rix = b[3:2];
				8'd3: ps_mode = b[7:6];
				default: ;
			endcase
			k = int'(ps_pos) - off;
			if (k >= 0 && k < 4 && b != magic[k]) begin
				r.kind   = vhp_pkg::KIND_NONE;
				got      = 1'b1;
				ps_phase = vhp_pkg::PH_IDLE;
			end else begin
				if (k == 3) begin
					ps_phase  = vhp_pkg::PH_FLAGS;
					ps_cursor = 8'd0;
					ps_shift  = '0;
				end
				if (ps_pos < 8'd255)
					ps_pos++;
			end
		end else if (ps_phase == vhp_pkg::PH_TOC) begin
			r.kind      = vhp_pkg::KIND_TOC;
			r.toc_index = ps_cursor[6:0];
			r.toc_value = b;
			got         = 1'b1;
			ps_cursor++;
			if (ps_cursor >= TOC_LEN) begin
				ps_cursor = 8'd0;
				ps_phase  = ps_flags[3] ? vhp_pkg::PH_SCALE : vhp_pkg::PH_PEND;
			end
		end else begin
			// big-endian 32-bit fields: flags, frames, bytes, scale
			ps_shift = {ps_shift[23:0], b};
			ps_cursor++;
			if (ps_cursor == 8'd4) begin
				ps_cursor = 8'd0;
				case (ps_phase)
					vhp_pkg::PH_FLAGS:  ps_flags  = ps_shift;
					vhp_pkg::PH_FRAMES: ps_frames = ps_shift;
					vhp_pkg::PH_BYTES:  ps_bytes  = ps_shift;
					default: ;
				endcase
				if (ps_phase == vhp_pkg::PH_SCALE) begin
					r        = xing_summary(ps_shift);
					got      = 1'b1;
					ps_phase = vhp_pkg::PH_IDLE;
				end else begin
					ps_phase = following_field(ps_phase);
					if (ps_phase == vhp_pkg::PH_IDLE) begin
						r   = xing_summary(vhp_pkg::SCALE_ABSENT);
						got = 1'b1;
					end
				end
				ps_shift = '0;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Random 32-bit word, leaning on the extremes now and then
	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Append one byte to the frame under construction
	task automatic add_frame_byte(input logic [7:0] v);
		frame_bytes.insert(frame_bytes.size(), v);
	endtask

	task automatic push_be_word(input logic [31:0] w);
		add_frame_byte(w[31:24]);
		add_frame_byte(w[23:16]);
		add_frame_byte(w[15:8]);
		add_frame_byte(w[7:0]);
	endtask

	// Queue one frame: mostly well formed, some with a broken magic word, some cut
	// short by the next sync byte, some plain noise
	task automatic plan_frame();
		int          roll;
		int          off;
		int          cut;
		logic [7:0]  hb;
		logic        ver;
		logic [1:0]  mode;
		logic [31:0] fl;
		frame_byte_t fb;
		frame_bytes.delete();
		roll = $urandom_range(99);
		add_frame_byte(8'($urandom));
		if (roll < 12) begin
			repeat ($urandom_range(45, 5))
				add_frame_byte(8'($urandom));
		end else begin
			hb  = 8'($urandom);
			ver = hb[3];
			add_frame_byte(hb);
			add_frame_byte(8'($urandom));
			hb   = 8'($urandom);
			mode = hb[7:6];
			add_frame_byte(hb);
			if (ver)
				off = (mode != vhp_pkg::MODE_MONO) ? vhp_pkg::OFF_M1_STEREO
					: vhp_pkg::OFF_M1_MONO;
			else
				off = (mode != vhp_pkg::MODE_MONO) ? vhp_pkg::OFF_M2_STEREO
					: vhp_pkg::OFF_M2_MONO;
			while (frame_bytes.size() < off)
				add_frame_byte(8'($urandom));
			add_frame_byte(vhp_pkg::MAGIC_0);
			add_frame_byte(vhp_pkg::MAGIC_1);
			add_frame_byte(vhp_pkg::MAGIC_2);
			add_frame_byte(vhp_pkg::MAGIC_3);
			if (roll < 22)
				frame_bytes[off + $urandom_range(3)] ^= 8'($urandom_range(255, 1));
			fl      = pick_word();
			fl[1:0] = 2'($urandom);
			fl[3]   = 1'($urandom);
			// keep seek tables to a minority of frames, they are long
			fl[2]   = ($urandom_range(99) < 30);
			push_be_word(fl);
			if (fl[0])
				push_be_word(pick_word());
			if (fl[1])
				push_be_word(pick_word());
			if (fl[2])
				repeat (TOC_LEN)
					add_frame_byte(8'($urandom));
			if (fl[3])
				push_be_word(pick_word());
			if ($urandom_range(99) < 15) begin
				cut = $urandom_range(frame_bytes.size() - 1, 1);
				while (frame_bytes.size() > cut)
					void'(frame_bytes.pop_back());
			end else begin
				// after a seek table with no scale field, zero trailing bytes leaves a pending summary for the next sync byte
				repeat ($urandom_range(3))
					add_frame_byte(8'($urandom));
			end
		end
		foreach (frame_bytes[i]) begin
			fb.data = frame_bytes[i];
			fb.sync = (i == 0);
			byte_plan.insert(byte_plan.size(), fb);
		end
	endtask

	// Present one byte, hold it until the transfer, return at the accepting edge
	task automatic offer_byte(input logic [7:0] b, input logic sync);
		while ($urandom_range(99) < src_idle_pct) begin
			data_valid <= 1'b0;
			@(posedge clk);
		end
		data_valid  <= 1'b1;
		data_byte   <= b;
		frame_start <= sync;
		@(negedge clk);
		while (!data_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0h, got %0h", name, want, seen);
			mismatch_count++;
		end
	endtask

	// ------------------------------------------------------------------
	// Checking: sample at the falling edge, where every signal is settled.
	// A transfer seen here completes at the next rising edge.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		bit               got;
		vhp_pkg::result_t pred;
		vhp_pkg::result_t want;
		if (!arst_n) begin
			// track the block's reset state: idle until a frame start
			ps_phase = vhp_pkg::PH_IDLE;
			clear_parse_state();
		end else begin
			if (data_valid && data_ready) begin
				parse_frame_byte(data_byte, frame_start, got, pred);
				case (row_check)
					CHK_TYPED:
						awaited_results.insert(awaited_results.size(), row_typed);
					CHK_NO_RESULT: ;
					default:
						if (got)
							awaited_results.insert(awaited_results.size(), pred);
				endcase
			end
			if (result_valid && result_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result transfer with nothing expected (kind %0d)", kind);
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("kind", want.kind, kind);
					check_field("toc_index", want.toc_index, toc_index);
					check_field("toc_value", want.toc_value, toc_value);
					check_field("flag_word", want.flag_word, flag_word);
					check_field("frame_count", want.frame_count, frame_count);
					check_field("byte_count", want.byte_count, byte_count);
					check_field("quality_scale", want.quality_scale, quality_scale);
					check_field("is_mpeg1", want.is_mpeg1, is_mpeg1);
					check_field("sample_rate", want.sample_rate, sample_rate);
				end
			end
		end
	end

	// Receiver: stall about a third of the time, never stall inside a fixed window
	always @(posedge clk) begin
		if (!arst_n)
			result_ready <= 1'b0;
		else
			result_ready <= (cycle_no >= 1500 && cycle_no < 3000) ? 1'b1
					: ($urandom_range(99) >= 35);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_no++;
		if (cycle_no > CYCLE_LIMIT) begin
			$display("tb_vbr_header_parser_core: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		vhp_pkg::result_t sum_typed;
		frame_byte_t      fb;
		int               sent;
		arst_n         = 1'b0;
		data_valid     = 1'b0;
		data_byte      = 8'd0;
		frame_start    = 1'b0;
		row_check      = CHK_MODEL;
		row_typed      = '0;
		src_idle_pct   = 35;

		// MPEG-2, rate index 2, mono, all flags clear: the summary closes the flag word
		sum_typed               = '0;
		sum_typed.kind          = vhp_pkg::KIND_SUMMARY;
		sum_typed.quality_scale = vhp_pkg::SCALE_ABSENT;
		sum_typed.is_mpeg1      = 1'b0;
		sum_typed.sample_rate   = 17'd16000;

		dir_rows = '{
			'{8'hA5, 1'b0, CHK_NO_RESULT, '0},   // before any sync byte: dropped
			'{8'hFF, 1'b1, CHK_NO_RESULT, '0},   // sync byte
			'{8'hF3, 1'b0, CHK_MODEL, '0},       // version bit clear: MPEG-2
			'{8'h88, 1'b0, CHK_MODEL, '0},       // rate index 2
			'{8'hC0, 1'b0, CHK_MODEL, '0},       // mono: info block at byte 13
			'{8'h00, 1'b0, CHK_MODEL, '0},
			'{8'hFF, 1'b0, CHK_MODEL, '0},
			'{8'h55, 1'b0, CHK_MODEL, '0},
			'{8'hAA, 1'b0, CHK_MODEL, '0},
			'{8'h01, 1'b0, CHK_MODEL, '0},
			'{8'h80, 1'b0, CHK_MODEL, '0},
			'{8'h7F, 1'b0, CHK_MODEL, '0},
			'{8'hFE, 1'b0, CHK_MODEL, '0},
			'{8'h3C, 1'b0, CHK_MODEL, '0},
			'{vhp_pkg::MAGIC_0, 1'b0, CHK_MODEL, '0},
			'{vhp_pkg::MAGIC_1, 1'b0, CHK_MODEL, '0},
			'{vhp_pkg::MAGIC_2, 1'b0, CHK_MODEL, '0},
			'{vhp_pkg::MAGIC_3, 1'b0, CHK_MODEL, '0},
			'{8'h00, 1'b0, CHK_MODEL, '0},
			'{8'h00, 1'b0, CHK_MODEL, '0},
			'{8'h00, 1'b0, CHK_MODEL, '0},
			'{8'h00, 1'b0, CHK_TYPED, sum_typed},
			'{8'h5A, 1'b0, CHK_NO_RESULT, '0}    // after the summary: dropped
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row_check = dir_rows[i].how;
			row_typed = dir_rows[i].typed;
			offer_byte(dir_rows[i].data, dir_rows[i].sync);
		end

		// Random frames; the sender never idles over a middle stretch
		row_check = CHK_MODEL;
		sent      = 0;
		while (sent < RAND_ITEMS) begin
			if (byte_plan.size() == 0)
				plan_frame();
			fb           = byte_plan.pop_front();
			src_idle_pct = (sent >= 400 && sent < 750) ? 0 : 35;
			offer_byte(fb.data, fb.sync);
			sent++;
		end
		data_valid <= 1'b0;

		// Drain, then wait on to expose any stray result
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb_vbr_header_parser_core: clean");
		else
			$display("tb_vbr_header_parser_core: errors");
		$finish;
	end

endmodule
